// ===== hw/rtl/utf8d_pkg.sv =====
// package: shared types, constants and the lead byte classifier for the utf-8 decoder
`timescale 1ns / 1ps
`default_nettype none
package utf8d_pkg;

    localparam int CP_WIDTH    = 21;
    localparam int IDX_OUT_W   = 32;
    localparam int INDEX_WIDTH = 32;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 1'b1;

    localparam logic [CP_WIDTH-1:0] REPLACEMENT_RESET = 21'h00FFFD;
    localparam logic [CP_WIDTH-1:0] TARGET_RESET      = 21'h000000;

    // one result item
    typedef struct packed {
        logic [CP_WIDTH-1:0]  code_point;
        logic                 malformed;
        logic                 matches_target;
        logic [IDX_OUT_W-1:0] point_index;
        logic                 last_of_run;
        logic                 text_done;
    } result_t;

    // up to two results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    // outcome of taking a byte as a lead byte
    typedef struct packed {
        logic                emit;
        logic                bad;
        logic [CP_WIDTH-1:0] cp;
        logic [1:0]          trails;
        logic [CP_WIDTH-1:0] partial;
        logic                set_partial;
    } lead_t;

    function automatic lead_t classify_lead(input logic [7:0] b,
                                            input logic [CP_WIDTH-1:0] repl);
        lead_t l;
        l = '0;
        if (b[7] == 1'b0) begin
            l.emit = 1'b1;
            l.cp   = CP_WIDTH'(b);
        end else if ((b & 8'hE0) == 8'hC0) begin
            l.trails      = 2'd1;
            l.partial     = CP_WIDTH'(b & 8'h1F);
            l.set_partial = 1'b1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            l.trails      = 2'd2;
            l.partial     = CP_WIDTH'(b & 8'h0F);
            l.set_partial = 1'b1;
        end else if ((b & 8'hF8) == 8'hF0) begin
            l.trails      = 2'd3;
            l.partial     = CP_WIDTH'(b & 8'h07);
            l.set_partial = 1'b1;
        end else begin
            l.emit = 1'b1;
            l.bad  = 1'b1;
            l.cp   = repl;
        end
        return l;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// top level: streaming utf-8 decoder with configuration registers
//
// The input channel (s_valid/s_ready) takes one text byte per item with an
// end-of-text flag. The result channel (m_valid/m_ready) gives one decoded
// code point per item, with a malformed flag, a target match flag, a running
// code point index within the text, and last-of-run / text-done markers.
// A byte yields zero, one or two results: a multibyte lead or a middle trail
// yields none before end of text; an interrupted sequence yields the
// replacement, then the new byte's own result if it gives one.
// Path: a byte is registered at the input and decoded into a two-entry
// result queue; the byte waits in the input register until there is room.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver keeps up; a byte that gives two results waits for the
// queue to empty and the byte after it waits for room. Room is counted
// before the same-cycle pop.
// Configuration (cfg_wr_en/cfg_index/cfg_wdata) is written by the user only
// while idle; the block does not enforce it. Index 0 is the replacement
// value, index 1 the search target. Reset clears the sequence state, index
// counter, input register and result queue and restores register defaults.
// On a receiver stall the queue fills and s_ready drops once no room is left.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_in_byte,
    input  wire logic                            s_end_of_text,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [utf8d_pkg::CP_WIDTH-1:0]       m_code_point,
    output logic                                 m_malformed,
    output logic                                 m_matches_target,
    output logic [utf8d_pkg::IDX_OUT_W-1:0]      m_point_index,
    output logic                                 m_last_of_run,
    output logic                                 m_text_done,
    input  wire logic                            cfg_wr_en,
    input  wire logic [utf8d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [utf8d_pkg::CP_WIDTH-1:0]  cfg_wdata
);
    import utf8d_pkg::*;

    logic [CP_WIDTH-1:0] replacement_reg;
    logic [CP_WIDTH-1:0] target_reg;
    push_t               push;
    logic [1:0]          q_free;
    result_t             head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replacement_reg <= REPLACEMENT_RESET;
            target_reg      <= TARGET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_REPLACEMENT: replacement_reg <= cfg_wdata;
                REG_TARGET:      target_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // byte decode
    utf8d_decode u_decode (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_end_of_text     (s_end_of_text),
        .replacement_value (replacement_reg),
        .target_codepoint  (target_reg),
        .q_free            (q_free),
        .push              (push)
    );

    // result queue
    utf8d_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .q_free  (q_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    // result fields
    assign m_code_point     = head.code_point;
    assign m_malformed      = head.malformed;
    assign m_matches_target = head.matches_target;
    assign m_point_index    = head.point_index;
    assign m_last_of_run    = head.last_of_run;
    assign m_text_done      = head.text_done;

endmodule
`default_nettype wire

// ===== hw/rtl/utf8d_decode.sv =====
// input register, sequence state and per-byte decode into up to two results
`timescale 1ns / 1ps
`default_nettype none
module utf8d_decode (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_in_byte,
    input  wire logic                          s_end_of_text,
    input  wire logic [utf8d_pkg::CP_WIDTH-1:0] replacement_value,
    input  wire logic [utf8d_pkg::CP_WIDTH-1:0] target_codepoint,
    input  wire logic [1:0]                    q_free,
    output utf8d_pkg::push_t                   push
);
    import utf8d_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   eot_reg;
    logic [CP_WIDTH-1:0]    partial_reg, partial_next;
    logic [1:0]             trails_reg, trails_next;
    logic [INDEX_WIDTH-1:0] counter_reg, counter_next;

    logic                   consume;
    logic                   is_trail;
    logic [CP_WIDTH-1:0]    shifted;
    logic [1:0]             trails_dec;
    lead_t                  lead;

    // candidate result slots: interrupt, main, truncation
    logic                   a_v, b_v, c_v;
    logic                   b_bad;
    logic [CP_WIDTH-1:0]    b_cp;
    logic [1:0]             seq_trails;
    logic [CP_WIDTH-1:0]    seq_partial;
    logic [1:0]             n;
    logic [CP_WIDTH-1:0]    cp0, cp1;
    logic                   bad0, bad1;

    assign is_trail   = (byte_reg[7:6] == 2'b10);
    assign shifted    = {partial_reg[CP_WIDTH-7:0], byte_reg[5:0]};
    assign trails_dec = trails_reg - 2'd1;
    assign lead       = classify_lead(byte_reg, replacement_value);

    // decode one byte against the current sequence state
    always_comb begin
        a_v         = 1'b0;
        b_v         = 1'b0;
        b_bad       = 1'b0;
        b_cp        = shifted;
        seq_trails  = trails_reg;
        seq_partial = partial_reg;
        if (trails_reg != 2'd0 && is_trail) begin
            seq_trails  = trails_dec;
            seq_partial = shifted;
            b_v         = (trails_dec == 2'd0);
        end else begin
            a_v         = (trails_reg != 2'd0);
            b_v         = lead.emit;
            b_bad       = lead.bad;
            b_cp        = lead.cp;
            seq_trails  = lead.trails;
            if (lead.set_partial) begin
                seq_partial = lead.partial;
            end
        end
        c_v = eot_reg && (seq_trails != 2'd0);
    end

    // pack valid slots to the front
    always_comb begin
        n    = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
        cp0  = replacement_value;
        bad0 = 1'b1;
        cp1  = replacement_value;
        bad1 = 1'b1;
        if (a_v) begin
            if (b_v) begin
                cp1  = b_cp;
                bad1 = b_bad;
            end
        end else if (b_v) begin
            cp0  = b_cp;
            bad0 = b_bad;
        end
    end

    assign consume = in_valid_reg && (n <= q_free);
    assign s_ready = !in_valid_reg || consume;

    // result items handed to the queue
    always_comb begin
        push.count             = consume ? n : 2'd0;
        push.r0.code_point     = cp0;
        push.r0.malformed      = bad0;
        push.r0.matches_target = (cp0 == target_codepoint);
        push.r0.point_index    = IDX_OUT_W'(counter_reg);
        push.r0.last_of_run    = (n == 2'd1);
        push.r0.text_done      = (n == 2'd1) && eot_reg;
        push.r1.code_point     = cp1;
        push.r1.malformed      = bad1;
        push.r1.matches_target = (cp1 == target_codepoint);
        push.r1.point_index    = IDX_OUT_W'(counter_reg + INDEX_WIDTH'(1));
        push.r1.last_of_run    = 1'b1;
        push.r1.text_done      = eot_reg;
    end

    // next sequence state, cleared at end of text
    always_comb begin
        if (eot_reg) begin
            trails_next  = 2'd0;
            partial_next = '0;
            counter_next = '0;
        end else begin
            trails_next  = seq_trails;
            partial_next = seq_partial;
            counter_next = counter_reg + INDEX_WIDTH'(n);
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            byte_reg <= s_in_byte;
            eot_reg  <= s_end_of_text;
        end
    end

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trails_reg  <= 2'd0;
            partial_reg <= '0;
            counter_reg <= '0;
        end else if (consume) begin
            trails_reg  <= trails_next;
            partial_reg <= partial_next;
            counter_reg <= counter_next;
        end
    end

    // every byte that ends a text yields a result
    a_eot_result: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && eot_reg |-> n != 2'd0)
        else $error("end of text byte produced no result");

    // state is back to zero after the end of a text
    a_eot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && eot_reg |=> trails_reg == 2'd0 && counter_reg == '0)
        else $error("state not cleared after end of text");

    // a byte never causes more than two results
    a_max_two: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> !(a_v && b_v && c_v))
        else $error("three results from one byte");

endmodule
`default_nettype wire

// ===== hw/rtl/utf8d_outq.sv =====
// two-entry result queue, head entry drives the result channel
`timescale 1ns / 1ps
`default_nettype none
module utf8d_outq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire utf8d_pkg::push_t push,
    output logic [1:0]            q_free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output utf8d_pkg::result_t    head
);
    import utf8d_pkg::*;

    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] keep;
    result_t    keep0;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign q_free  = 2'd2 - count_reg;
    assign head    = e0_reg;

    // drop the head on a pop, then append new items behind what is kept
    always_comb begin
        keep       = count_reg - {1'b0, pop};
        keep0      = pop ? e1_reg : e0_reg;
        e0_next    = (keep != 2'd0) ? keep0 : push.r0;
        case (keep)
            2'd2:    e1_next = e1_reg;
            2'd1:    e1_next = push.r0;
            default: e1_next = push.r1;
        endcase
        count_next = keep + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    // occupancy stays within two entries
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue overflow");

    // a pair of results only arrives into an empty queue
    a_pair_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> count_reg == 2'd0)
        else $error("pair pushed into occupied queue");

    // in a pair only the second item closes the run
    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> !push.r0.last_of_run && push.r1.last_of_run)
        else $error("last_of_run misplaced in pair");

endmodule
`default_nettype wire
